// ===== rtl/rgd_pkg.sv =====
// ----------------------------------------------------------------------------
// rgd_pkg: shared types and constants of the regular grid detector
// Sample width codes, register indexes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rgd_pkg;

  localparam int SAMPLE_W = 64;
  localparam int IN_DATA_W = 64;
  localparam int OUT_DATA_W = 136;

  // Output beat layout.
  localparam int OUT_REG_BIT = 0;
  localparam int OUT_START_LO = 1;
  localparam int OUT_STEP_LO = 65;

  // Configuration registers.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_CODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED = 1'b1;

  // Sample width codes.
  localparam logic [1:0] WCODE_8 = 2'd0;
  localparam logic [1:0] WCODE_16 = 2'd1;
  localparam logic [1:0] WCODE_32 = 2'd2;
  localparam logic [1:0] WCODE_64 = 2'd3;
  localparam logic [1:0] WCODE_RESET = WCODE_32;

  // Restoring division, one quotient bit per cycle.
  localparam int DIV_STEPS = 64;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  typedef enum logic [3:0] {
    ST_ACC  = 4'b0001,
    ST_PREP = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_LOAD = 4'b1000
  } state_t;

  typedef struct packed {
    logic sample_en;
    logic div_prep;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic regular_now;
  } dp_status_t;

  function automatic logic [SAMPLE_W-1:0] width_mask(logic [1:0] code);
    logic [SAMPLE_W-1:0] m;
    case (code)
      WCODE_8:  m = {56'd0, 8'hff};
      WCODE_16: m = {48'd0, 16'hffff};
      WCODE_32: m = {32'd0, 32'hffff_ffff};
      default:  m = {SAMPLE_W{1'b1}};
    endcase
    return m;
  endfunction

  // Reduce to the sample width and extend per signedness.
  function automatic logic [SAMPLE_W-1:0] extend_sample(logic [SAMPLE_W-1:0] v,
                                                        logic [1:0] code,
                                                        logic sgn);
    logic [SAMPLE_W-1:0] r;
    case (code)
      WCODE_8:  r = {{56{sgn & v[7]}}, v[7:0]};
      WCODE_16: r = {{48{sgn & v[15]}}, v[15:0]};
      WCODE_32: r = {{32{sgn & v[31]}}, v[31:0]};
      default:  r = v;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/rgd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rgd_ctrl: controller of the regular grid detector
// Sequences sample intake, the serial division and the output register.
// ----------------------------------------------------------------------------
module rgd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_tlast,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  rgd_pkg::dp_status_t status,
  output rgd_pkg::dp_cmd_t    cmd
);

  rgd_pkg::state_t state_r, state_nxt;
  logic [rgd_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  assign in_tready = (state_r == rgd_pkg::ST_ACC);
  assign accept = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    cmd.sample_en = accept;
    unique case (state_r)
      rgd_pkg::ST_ACC: begin
        if (accept && in_tlast) begin
          state_nxt = status.regular_now ? rgd_pkg::ST_PREP : rgd_pkg::ST_LOAD;
        end
      end
      rgd_pkg::ST_PREP: begin
        cmd.div_prep = 1'b1;
        cnt_nxt = '0;
        state_nxt = rgd_pkg::ST_DIV;
      end
      rgd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == rgd_pkg::DIV_LAST) begin
          state_nxt = rgd_pkg::ST_LOAD;
        end
      end
      rgd_pkg::ST_LOAD: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt = rgd_pkg::ST_ACC;
        end
      end
      default: state_nxt = rgd_pkg::ST_ACC;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rgd_pkg::ST_ACC;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/rgd_datapath.sv =====
// ----------------------------------------------------------------------------
// rgd_datapath: datapath of the regular grid detector
// Run state, configuration registers, serial divider and output register.
// ----------------------------------------------------------------------------
module rgd_datapath #(
  parameter int COUNT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rgd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rgd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [rgd_pkg::SAMPLE_W-1:0]        sample,
  input  logic                                last,
  input  rgd_pkg::dp_cmd_t                    cmd,
  output rgd_pkg::dp_status_t                 status,
  output logic                                out_regular,
  output logic [rgd_pkg::SAMPLE_W-1:0]        out_start,
  output logic [rgd_pkg::SAMPLE_W-1:0]        out_step
);

  localparam int W = rgd_pkg::SAMPLE_W;

  logic [1:0] wcode_r;
  logic       signed_r;

  logic [W-1:0] first_r, prev_r, fdiff_r;
  logic         still_r, still_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;

  logic [W-1:0] mask, diff_cur, ext_v, ext_first, span;
  logic         unsigned_mode, mismatch;

  // Division operands and running state.
  logic [W-1:0]          quo_r;
  logic [COUNT_BITS-1:0] rem_r, divisor_r;
  logic                  neg_r, regular_r;
  logic [W-1:0]          start_r;
  logic [COUNT_BITS:0]   rem_sh, rem_sub;
  logic                  q_bit;
  logic [W-1:0]          q_signed;

  logic          out_regular_r;
  logic [W-1:0]  out_start_r, out_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcode_r <= rgd_pkg::WCODE_RESET;
      signed_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rgd_pkg::REG_WIDTH_CODE: wcode_r <= cfg_wdata[1:0];
        rgd_pkg::REG_SIGNED:     signed_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign mask = rgd_pkg::width_mask(wcode_r);
  assign diff_cur = (sample - prev_r) & mask;
  assign mismatch = (count_r >= COUNT_BITS'(2)) && (diff_cur != (fdiff_r & mask));
  assign still_nxt = still_r & ~mismatch;
  assign count_nxt = (&count_r) ? count_r : count_r + 1'b1;
  assign status.regular_now = still_nxt && (count_r >= COUNT_BITS'(2));

  assign unsigned_mode = !signed_r &&
                         (wcode_r == rgd_pkg::WCODE_32 || wcode_r == rgd_pkg::WCODE_64);
  assign ext_v = rgd_pkg::extend_sample(sample, wcode_r, signed_r);
  assign ext_first = rgd_pkg::extend_sample((count_r == '0) ? sample : first_r,
                                            wcode_r, signed_r);
  assign span = ext_v - ext_first;

  // Run state: cleared on the marked sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      still_r <= 1'b1;
      count_r <= '0;
    end else if (cmd.sample_en) begin
      if (last) begin
        still_r <= 1'b1;
        count_r <= '0;
      end else begin
        still_r <= still_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sample_en) begin
      prev_r <= sample;
      if (count_r == '0) begin
        first_r <= sample;
      end
      if (count_r == COUNT_BITS'(1)) begin
        fdiff_r <= diff_cur;
      end
    end
  end

  // Restoring division step.
  assign rem_sh = {rem_r, quo_r[W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor_r};
  assign q_bit = ~rem_sub[COUNT_BITS];
  assign q_signed = neg_r ? (~quo_r + 1'b1) : quo_r;

  always_ff @(posedge clk) begin
    if (cmd.sample_en && last) begin
      // Capture the span; its sign is resolved in the following cycle.
      quo_r <= unsigned_mode ? (span & mask) : span;
      neg_r <= !unsigned_mode && span[W-1];
      divisor_r <= count_nxt - 1'b1;
      regular_r <= status.regular_now;
      start_r <= ext_first;
      rem_r <= '0;
    end else if (cmd.div_prep) begin
      quo_r <= q_signed;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[W-2:0], q_bit};
      rem_r <= q_bit ? rem_sub[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_regular_r <= regular_r;
      out_start_r <= start_r;
      out_step_r <= regular_r ? rgd_pkg::extend_sample(q_signed, wcode_r, signed_r) : '0;
    end
  end

  assign out_regular = out_regular_r;
  assign out_start = out_start_r;
  assign out_step = out_step_r;

endmodule

// ===== rtl/regular_grid_detector.sv =====
// ----------------------------------------------------------------------------
// regular_grid_detector: evenly spaced axis detection
// Checks whether the samples of one axis array step by a constant amount and
// reports the start value and the mean step after the last sample arrives.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Beat contents
//   in_*     input      one axis sample; tlast marks the final sample
//   out_*    output     one result per array: regular flag, start, mean step
//   cfg_*    input      register writes: width code, signedness
//
// A sample that is not the last of its array is taken as soon as it is valid,
// and samples stream back to back. After the last sample of an array that is
// not regular, the controller loads the output register. For a regular
// array the mean step comes from a radix-2 restoring divider: a sign step,
// the quotient steps and a load step, with in_tready low throughout.
// The result waits in the output register while the next array streams in;
// only a later load stalls while out_tready holds the previous result.
// Reset is synchronous and active low; no clearing pass is needed.
//
module regular_grid_detector #(
  parameter int COUNT_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // tdata: [63:0] sample_value
  input  logic [rgd_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic                             in_tlast,
  // tdata: [0] is_regular, [64:1] start_value, [128:65] step_value, zero fill
  output logic [rgd_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic [rgd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rgd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  rgd_pkg::dp_cmd_t    cmd;
  rgd_pkg::dp_status_t status;

  logic                          res_regular;
  logic [rgd_pkg::SAMPLE_W-1:0]  res_start, res_step;

  rgd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  rgd_datapath #(
    .COUNT_BITS(COUNT_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .sample     (in_tdata),
    .last       (in_tlast),
    .cmd        (cmd),
    .status     (status),
    .out_regular(res_regular),
    .out_start  (res_start),
    .out_step   (res_step)
  );

  // Pack the result beat, lowest field first, zero filled to whole bytes.
  assign out_tdata = {7'd0, res_step, res_start, res_regular};

  // After the last sample of an array the block takes no sample until the
  // result has been loaded.
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("sample accepted right after the last sample of an array");

  // The divider never runs while samples are being taken.
  a_div_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step || cmd.div_prep) |-> !in_tready)
    else $error("divider active while the input is open");

  // A loaded result is presented in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("loaded result not presented");

  // An irregular array reports a zero step.
  a_irregular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[rgd_pkg::OUT_REG_BIT]) |->
      (out_tdata[rgd_pkg::OUT_STEP_LO +: rgd_pkg::SAMPLE_W] == '0))
    else $error("nonzero step reported for an irregular array");

endmodule

// ===== sim/regular_grid_detector_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// regular_grid_detector_tb: self-checking bench for the regular grid detector
// Streams axis arrays through the block under every width and signedness
// setting. A predictor run in lockstep with each accepted beat works out the
// expected regular flag, start value and mean step. Each result beat is
// checked against the oldest expectation.
// ----------------------------------------------------------------------------
module regular_grid_detector_tb;

  // The block stays busy after the last beat of a regular array while it divides.
  // This margin covers that before register writes and at the end of the run.
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASE_BEATS = 195;

  typedef struct packed {
    logic        regular;
    logic [63:0] start;
    logic [63:0] step;
  } grid_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic [rgd_pkg::IN_DATA_W-1:0]   in_tdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic                            in_tlast = 1'b0;
  logic [rgd_pkg::OUT_DATA_W-1:0]  out_tdata;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [rgd_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [rgd_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Register settings as the block should currently hold them.
  logic [1:0]  cur_wcode = rgd_pkg::WCODE_RESET;
  logic        cur_signed = 1'b1;

  // Running state of the array now being streamed.
  logic [63:0] acc_first = '0;
  logic [63:0] acc_prev = '0;
  logic [63:0] acc_diff0 = '0;
  logic        acc_even = 1'b1;
  logic [31:0] acc_count = '0;

  grid_result_t expected_grids[$];
  grid_result_t got_grid;
  grid_result_t want_grid;

  int  mismatches = 0;
  bit  src_gaps = 1'b0;
  bit  sink_gaps = 1'b0;
  int  sink_hold = 0;

  regular_grid_detector i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tlast  (in_tlast),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // All ones in the low W bits of a sample at the current width.
  function automatic logic [63:0] lane_mask(input logic [1:0] code);
    int w;
    w = 8 << code;
    return ~64'd0 >> (64 - w);
  endfunction

  // Cut a value to the sample width, then sign or zero extend it.
  function automatic logic [63:0] fit_to_lane(input logic [63:0] v);
    logic [63:0] m;
    logic [63:0] r;
    int          w;
    m = lane_mask(cur_wcode);
    w = 8 << cur_wcode;
    r = v & m;
    if (w < 64 && cur_signed && r[w-1]) begin
      r = r | ~m;
    end
    return r;
  endfunction

  // Fold one accepted sample into the running array state. On the marked
  // sample the expected result is queued and the state starts over.
  function automatic void track_grid_sample(input logic [63:0] v, input logic last);
    logic [63:0]  m;
    logic [63:0]  d;
    logic [63:0]  span;
    logic [63:0]  mag;
    logic [63:0]  q;
    logic         neg;
    grid_result_t r;
    m = lane_mask(cur_wcode);
    if (acc_count == 0) begin
      acc_first = v;
    end else begin
      // Each difference is taken at the width in force for this sample.
      d = (v - acc_prev) & m;
      if (acc_count == 1) begin
        acc_diff0 = d;
      end else if (d != (acc_diff0 & m)) begin
        acc_even = 1'b0;
      end
    end
    acc_prev = v;
    if (acc_count != '1) begin
      acc_count = acc_count + 1;
    end
    if (last) begin
      r.regular = acc_even && (acc_count >= 3);
      r.start = fit_to_lane(acc_first);
      r.step = '0;
      if (r.regular) begin
        span = fit_to_lane(acc_prev) - fit_to_lane(acc_first);
        // Wide unsigned samples wrap and divide unsigned; everything else
        // divides the signed span with truncation toward zero.
        if (!cur_signed && cur_wcode >= rgd_pkg::WCODE_32) begin
          q = (span & m) / (64'(acc_count) - 64'd1);
        end else begin
          neg = span[63];
          mag = neg ? 64'd0 - span : span;
          q = mag / (64'(acc_count) - 64'd1);
          if (neg) begin
            q = 64'd0 - q;
          end
        end
        r.step = fit_to_lane(q);
      end
      expected_grids.push_back(r);
      acc_first = '0;
      acc_prev = '0;
      acc_diff0 = '0;
      acc_even = 1'b1;
      acc_count = '0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic flag_error(input string what, input logic [63:0] want,
                            input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %h, got %h", what, want, got);
    end
  endtask

  // Every result beat is paired with the oldest outstanding expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_grid.regular = out_tdata[rgd_pkg::OUT_REG_BIT];
      got_grid.start = out_tdata[rgd_pkg::OUT_START_LO +: 64];
      got_grid.step = out_tdata[rgd_pkg::OUT_STEP_LO +: 64];
      if (expected_grids.size() == 0) begin
        flag_error("unexpected result start", '0, got_grid.start);
      end else begin
        want_grid = expected_grids.pop_front();
        if (got_grid.regular !== want_grid.regular) begin
          flag_error("is_regular", 64'(want_grid.regular), 64'(got_grid.regular));
        end
        if (got_grid.start !== want_grid.start) begin
          flag_error("start_value", want_grid.start, got_grid.start);
        end
        if (got_grid.step !== want_grid.step) begin
          flag_error("step_value", want_grid.step, got_grid.step);
        end
      end
    end
  end

  // The receiver stalls in random bursts while enabled.
  always @(negedge clk) begin
    if (!sink_gaps) begin
      sink_hold = 0;
      out_tready <= 1'b1;
    end else if (sink_hold > 0) begin
      sink_hold--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      sink_hold = $urandom_range(1, 19) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Present one sample and hold it until the block takes the beat. Valid is
  // left high afterwards so that samples can follow back to back.
  task automatic send_sample(input logic [63:0] v, input logic last);
    int gap;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata <= {$urandom, $urandom};
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= v;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    track_grid_sample(v, last);
  endtask

  // Drop valid, let every expected result drain, then give the block time to
  // finish any division still running before the bus is touched again.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_grids.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rgd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rgd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == rgd_pkg::REG_WIDTH_CODE) begin
      cur_wcode = data[1:0];
    end else begin
      cur_signed = data[0];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_format(input logic [1:0] code, input logic sgn);
    settle();
    write_reg(rgd_pkg::REG_WIDTH_CODE, rgd_pkg::CFG_DATA_W'(code));
    write_reg(rgd_pkg::REG_SIGNED, rgd_pkg::CFG_DATA_W'(sgn));
  endtask

  // One array with random shape: mostly evenly spaced runs with random start
  // and step, some with a single damaged sample, some pure noise, plus the
  // odd one- or two-sample array and a few longer ones.
  task automatic send_random_array(output int n);
    int          pick;
    int          kind;
    int          bad_at;
    logic [63:0] start;
    logic [63:0] step;
    logic [63:0] m;
    logic [63:0] v;
    m = lane_mask(cur_wcode);
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      n = 1;
    end else if (pick == 1) begin
      n = 2;
    end else if (pick == 2) begin
      n = $urandom_range(20, 60);
    end else begin
      n = $urandom_range(3, 10);
    end
    kind = $urandom_range(0, 9);
    bad_at = $urandom_range(0, n - 1);
    start = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0) begin
      step = 64'($signed($urandom_range(0, 20)) - 10);
    end else begin
      step = {$urandom, $urandom};
    end
    for (int i = 0; i < n; i++) begin
      v = start + 64'(i) * step;
      if (kind >= 7 && kind <= 8 && i == bad_at) begin
        v = v ^ (64'd1 << $urandom_range(0, (8 << cur_wcode) - 1));
      end else if (kind == 9) begin
        v = {$urandom, $urandom};
      end
      // Bits above the sample width are junk the block must ignore.
      if ($urandom_range(0, 1) == 0) begin
        v = (v & m) | ({$urandom, $urandom} & ~m);
      end
      send_sample(v, i == n - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Arrays of one and two samples are never regular and report a zero step.
  task automatic test_short_arrays();
    send_sample(64'h0123_4567_89ab_cdef, 1'b1);
    send_sample(64'hffff_ffff_0000_0010, 1'b0);
    send_sample(64'h0000_0000_0000_0020, 1'b1);
  endtask

  // Reset format (32-bit signed), stepping down through the signed extremes
  // and wrapping once, with junk in the upper half of most samples.
  task automatic test_reset_format();
    send_sample(64'hdead_beef_7fff_ffff, 1'b0);
    send_sample(64'h0000_0000_0000_0000, 1'b0);
    send_sample(64'h1234_5678_8000_0001, 1'b0);
    send_sample(64'hffff_ffff_0000_0002, 1'b1);
  endtask

  // One bad sample in an otherwise even run: not regular, step is zero but
  // the start value is still reported.
  task automatic test_uneven_array();
    send_sample(64'h0000_0000_0000_0005, 1'b0);
    send_sample(64'h0000_0000_0000_000a, 1'b0);
    send_sample(64'h0000_0000_0000_0010, 1'b0);
    send_sample(64'h0000_0000_0000_0014, 1'b1);
  endtask

  // The width changes between two samples of the same array. The first
  // difference is taken at 16 bits and the second at 8 bits, where they match.
  task automatic test_midarray_format();
    set_format(rgd_pkg::WCODE_16, 1'b1);
    send_sample(64'h0000_0000_0000_0100, 1'b0);
    send_sample(64'h0000_0000_0000_0205, 1'b0);
    settle();
    write_reg(rgd_pkg::REG_WIDTH_CODE, rgd_pkg::CFG_DATA_W'(rgd_pkg::WCODE_8));
    send_sample(64'h0000_0000_0000_030a, 1'b1);
  endtask

  // A 64-bit unsigned span from zero to one below the top, and an 8-bit signed run
  // that goes from the largest to nearly the smallest value.
  task automatic test_width_extremes();
    set_format(rgd_pkg::WCODE_64, 1'b0);
    send_sample(64'h0000_0000_0000_0000, 1'b0);
    send_sample(64'h7fff_ffff_ffff_ffff, 1'b0);
    send_sample(64'hffff_ffff_ffff_fffe, 1'b1);
    set_format(rgd_pkg::WCODE_8, 1'b1);
    send_sample(64'hffff_ffff_ffff_ff7f, 1'b0);
    send_sample(64'h5a5a_5a5a_5a5a_5a00, 1'b0);
    send_sample(64'h0000_0000_0000_0081, 1'b1);
  endtask

  // Random arrays across every format. The first eight phases visit each
  // width and signedness pair, then one random format, and the final phase
  // runs 64-bit signed with both sides streaming flat out.
  task automatic test_random_sweep();
    int n;
    int sent;
    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 8) begin
        set_format(ph[1:0], ph[2]);
      end else if (ph == 8) begin
        set_format(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end else begin
        set_format(rgd_pkg::WCODE_64, 1'b1);
      end
      src_gaps = (ph < 9) && ($urandom_range(0, 3) != 0);
      sink_gaps = (ph < 9) && ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < PHASE_BEATS) begin
        send_random_array(n);
        sent += n;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_short_arrays();
    test_reset_format();
    test_uneven_array();
    test_midarray_format();
    test_width_extremes();
    test_random_sweep();
    settle();
    mismatches += expected_grids.size();
    if (mismatches == 0) begin
      $display("regular_grid_detector_tb: done, clean");
    end else begin
      $display("regular_grid_detector_tb: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, where every array is
  // regular and both sides stall as long as they ever do.
  initial begin
    #4_000_000;
    $display("regular_grid_detector_tb: done, errors");
    $finish;
  end

endmodule

// ===== regular_grid_detector.f =====
rtl/rgd_pkg.sv
rtl/rgd_ctrl.sv
rtl/rgd_datapath.sv
rtl/regular_grid_detector.sv
sim/regular_grid_detector_tb.sv
